FILE: sv/msbp_pkg.sv
// Shared types and constants for the MSB-first bit packer.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package msbp_pkg;

	localparam int unsigned VALUE_W  = 64;  // code word width
	localparam int unsigned COUNT_W  = 7;   // bit count field width
	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned PEND_W   = 7;   // pending bits, right aligned
	localparam int unsigned PCNT_W   = 3;   // pending bit count 0..7
	localparam int unsigned NB_W     = 4;   // bytes per transaction 0..8
	localparam int unsigned MAX_BITS = 64;  // saturation limit of bit_count
	localparam int unsigned QDEPTH   = 2;   // job queue depth

	// Input commands
	typedef enum logic {
		CMD_WRITE = 1'b0,
		CMD_FLUSH = 1'b1
	} cmd_t;

	// One job handed from the front to the back: up to eight bytes,
	// left aligned, first byte in the top bits.
	typedef struct packed {
		logic [VALUE_W-1:0] chunk;
		logic [NB_W-1:0]    nbytes;
	} job_t;

	// Job queue status seen by its neighbors
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

`default_nettype wire

FILE: sv/msbp_front.sv
// Front end: accepts input transactions, merges them with the pending
// partial byte and produces byte jobs. Depends on msbp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module msbp_front (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          push,
	output logic                               full,
	input  wire logic                          command,
	input  wire logic [msbp_pkg::VALUE_W-1:0]  value,
	input  wire logic [msbp_pkg::COUNT_W-1:0]  bit_count,
	input  wire msbp_pkg::q_stat_t             q_stat,
	output logic                               q_wr,
	output msbp_pkg::job_t                     q_job
);

	logic [msbp_pkg::PEND_W-1:0]  pend_q;
	logic [msbp_pkg::PCNT_W-1:0]  pcnt_q;

	logic                              accept;
	logic [msbp_pkg::COUNT_W-1:0]      n;
	logic [msbp_pkg::BYTE_W-1:0]       p_al;
	logic [msbp_pkg::VALUE_W-1:0]      v_al;
	logic [msbp_pkg::VALUE_W-1:0]      vmask;
	logic [msbp_pkg::VALUE_W+7:0]      comb72;
	logic [msbp_pkg::COUNT_W-1:0]      total;
	logic [msbp_pkg::PCNT_W-1:0]       rem;
	logic [msbp_pkg::VALUE_W+6:0]      stream;
	logic [msbp_pkg::PEND_W-1:0]       rmask;
	logic [msbp_pkg::PEND_W-1:0]       pend_d;
	logic [msbp_pkg::PCNT_W-1:0]       pcnt_d;

	assign full   = q_stat.full;
	assign accept = push && !q_stat.full;

	// Saturate the bit count
	always_comb begin
		if (bit_count > msbp_pkg::COUNT_W'(msbp_pkg::MAX_BITS)) begin
			n = msbp_pkg::COUNT_W'(msbp_pkg::MAX_BITS);
		end else begin
			n = bit_count;
		end
	end

	// Left-align pending bits and new bits, then join them into one string
	always_comb begin
		p_al   = 8'({1'b0, pend_q} << (4'd8 - {1'b0, pcnt_q}));
		v_al   = value << (msbp_pkg::COUNT_W'(msbp_pkg::MAX_BITS) - n);
		comb72 = {p_al, 64'b0} | ({v_al, 8'b0} >> pcnt_q);
		total  = {4'b0, pcnt_q} + n;
		rem    = total[2:0];
		// right-aligned stream gives the leftover bits directly
		vmask  = ~({msbp_pkg::VALUE_W{1'b1}} << n);
		stream = ({64'b0, pend_q} << n) | {7'b0, value & vmask};
		rmask  = ~(7'h7f << rem);
	end

	// Job and next pending state
	always_comb begin
		if (command == msbp_pkg::CMD_FLUSH) begin
			q_job.chunk  = {p_al, 56'b0};
			q_job.nbytes = (pcnt_q != '0) ? msbp_pkg::NB_W'(1) : '0;
			pend_d       = '0;
			pcnt_d       = '0;
		end else begin
			q_job.chunk  = comb72[71:8];
			q_job.nbytes = total[6:3];
			pend_d       = stream[6:0] & rmask;
			pcnt_d       = rem;
		end
	end

	assign q_wr = accept && (q_job.nbytes != '0);

	// Pending partial byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
			pcnt_q <= '0;
		end else if (accept) begin
			pend_q <= pend_d;
			pcnt_q <= pcnt_d;
		end
	end

	// A job never carries more than eight bytes
	a_job_size: assert property (@(posedge clk) disable iff (!arst_n)
		q_wr |-> (q_job.nbytes <= msbp_pkg::NB_W'(8)))
		else $error("front produced an oversized job");

	// A flush leaves nothing pending
	a_flush_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && command == msbp_pkg::CMD_FLUSH) |=> (pcnt_q == '0 && pend_q == '0))
		else $error("flush left pending bits");

endmodule

`default_nettype wire

FILE: sv/msbp_fifo.sv
// Short job queue between front and back end, register based.
// Depends on msbp_pkg for the job type and depth.
`timescale 1ns / 1ps
`default_nettype none

module msbp_fifo (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            wr,
	input  wire msbp_pkg::job_t  wr_job,
	input  wire logic            rd,
	output msbp_pkg::job_t       rd_job,
	output msbp_pkg::q_stat_t    stat
);

	localparam int unsigned PTR_W = (msbp_pkg::QDEPTH > 1) ? $clog2(msbp_pkg::QDEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(msbp_pkg::QDEPTH + 1);

	msbp_pkg::job_t    mem_q [msbp_pkg::QDEPTH];
	logic [PTR_W-1:0]  wptr_q;
	logic [PTR_W-1:0]  rptr_q;
	logic [CNT_W-1:0]  cnt_q;

	assign stat.full  = (cnt_q == CNT_W'(msbp_pkg::QDEPTH));
	assign stat.empty = (cnt_q == '0);
	assign rd_job     = mem_q[rptr_q];

	// Entry storage
	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wptr_q] <= wr_job;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (wr) begin
				wptr_q <= (wptr_q == PTR_W'(msbp_pkg::QDEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (rd) begin
				rptr_q <= (rptr_q == PTR_W'(msbp_pkg::QDEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (wr && !rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd && !wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr && stat.full))
		else $error("job queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(rd && stat.empty))
		else $error("job queue underflow");

endmodule

`default_nettype wire

FILE: sv/msbp_back.sv
// Back end: takes jobs from the queue and hands out one byte per pop.
// Its shift register is the output register. Depends on msbp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module msbp_back (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire msbp_pkg::q_stat_t             q_stat,
	input  wire msbp_pkg::job_t                q_job,
	output logic                               q_rd,
	output logic [msbp_pkg::BYTE_W-1:0]        out_byte,
	output logic                               last,
	output logic                               empty,
	input  wire logic                          pop
);

	logic [msbp_pkg::VALUE_W-1:0]  chunk_q;
	logic [msbp_pkg::NB_W-1:0]     rem_q;
	logic                          take;

	assign empty    = (rem_q == '0);
	assign out_byte = chunk_q[msbp_pkg::VALUE_W-1 -: msbp_pkg::BYTE_W];
	assign last     = (rem_q == msbp_pkg::NB_W'(1));
	assign take     = pop && !empty;

	// Load the next job when idle or when the last byte leaves
	assign q_rd = !q_stat.empty && (empty || (take && last));

	// Remaining byte count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
		end else if (q_rd) begin
			rem_q <= q_job.nbytes;
		end else if (take) begin
			rem_q <= rem_q - 1'b1;
		end
	end

	// Byte shift register
	always_ff @(posedge clk) begin
		if (q_rd) begin
			chunk_q <= q_job.chunk;
		end else if (take) begin
			chunk_q <= chunk_q << msbp_pkg::BYTE_W;
		end
	end

	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		rem_q <= msbp_pkg::NB_W'(8))
		else $error("back end byte count out of range");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (rem_q == $past(rem_q)))
		else $error("back end advanced without a pop");

endmodule

`default_nettype wire

FILE: sv/msb_first_bit_packer_core.sv
// MSB-first bit packer, top level.
// Instantiates msbp_front, msbp_fifo and msbp_back; uses msbp_pkg.
//
// Usage:
//   Input side is a queue write port: a transaction is taken on a rising edge
//   with push high and full low. command 0 appends the low bit_count bits of
//   value (counts above 64 act as 64), command 1 flushes the pending partial
//   byte padded with zeros. Output side is a queue read port: while empty is
//   low, out_byte/last hold the oldest byte, taken on an edge with pop high.
//   last marks the final byte caused by one input transaction.
// Timing:
//   One input transaction per cycle while full is low. A completed byte is
//   written into the job queue, then loaded into the output register, where
//   it can be popped. The back end delivers one byte per cycle while pop is
//   high; a code that completes k bytes occupies the output for k pops. The
//   two-entry job queue absorbs the difference and full rises when it fills.
// Reset:
//   arst_n clears the pending bits and empties the queue and output register.
// Stall:
//   While pop stays low the current byte holds, the queue fills, and then
//   full goes high until bytes drain.
`timescale 1ns / 1ps
`default_nettype none

module msb_first_bit_packer_core (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          push,
	output logic                               full,
	input  wire logic                          command,
	input  wire logic [msbp_pkg::VALUE_W-1:0]  value,
	input  wire logic [msbp_pkg::COUNT_W-1:0]  bit_count,
	output logic                               empty,
	input  wire logic                          pop,
	output logic [msbp_pkg::BYTE_W-1:0]        out_byte,
	output logic                               last
);

	msbp_pkg::q_stat_t  q_stat;
	msbp_pkg::job_t     wr_job;
	msbp_pkg::job_t     rd_job;
	logic               q_wr;
	logic               q_rd;

	msbp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.command   (command),
		.value     (value),
		.bit_count (bit_count),
		.q_stat    (q_stat),
		.q_wr      (q_wr),
		.q_job     (wr_job)
	);

	msbp_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (q_wr),
		.wr_job (wr_job),
		.rd     (q_rd),
		.rd_job (rd_job),
		.stat   (q_stat)
	);

	msbp_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_stat   (q_stat),
		.q_job    (rd_job),
		.q_rd     (q_rd),
		.out_byte (out_byte),
		.last     (last),
		.empty    (empty),
		.pop      (pop)
	);

endmodule

`default_nettype wire
